// File: rtl/hsv_pkg.sv
// hsv_pkg: constants and types for the hsv to rgb colour converter
// no dependencies; imported by hsv_to_rgb_converter

package hsv_pkg;

	localparam int unsigned HUE_STEPS = 255;
	localparam int unsigned FULL_SQ   = 65025;

	// 60 degree sectors of the hue circle
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: 8-bit hsv to rgb colour conversion, six-stage pipeline
// a word taken at start passes through stages s1 to s6 and is then on red/green/blue with done
// throughput: one word every cycle; busy is always low, the receiver cannot stall
// reset: arst_n clears the valid bits only; data registers are not reset
// depends on hsv_pkg

module hsv_to_rgb_converter
	import hsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	localparam logic [7:0]  STEPS8  = 8'(HUE_STEPS);
	localparam logic [15:0] FULL16  = 16'(FULL_SQ);
	localparam logic [17:0] FULL18  = 18'(FULL_SQ);
	localparam logic [17:0] FULL18X2 = 18'(2 * FULL_SQ);

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage 1: hue modulo 255
	logic [7:0]  hm_s1, sat_s1, bri_s1;
	// stage 2: sector, remainder, p product
	sector_t     sec_s2;
	logic [7:0]  rem_s2, sat_s2, bri_s2;
	logic [15:0] pprod_s2;
	// stage 3: losses and p
	sector_t     sec_s3;
	logic [15:0] lossq_s3, losst_s3;
	logic [7:0]  p_s3, bri_s3;
	// stage 4: q and t products
	sector_t     sec_s4;
	logic [23:0] prodq_s4, prodt_s4;
	logic [7:0]  p_s4, bri_s4;
	// stage 5: quotient estimate and remainder
	sector_t     sec_s5;
	logic [7:0]  eq_s5, et_s5, p_s5, bri_s5;
	logic [17:0] rq_s5, rt_s5;
	// stage 6: outputs
	logic [7:0]  red_s6, green_s6, blue_s6;

	logic [8:0]  fold1, fold2;
	logic [7:0]  hm_c;
	logic [10:0] pos_c;
	sector_t     sec_c;
	logic [10:0] base_c;
	logic [16:0] psum_c;
	logic [7:0]  p_c;
	logic [15:0] remb_c;
	logic [16:0] eq511_c, et511_c;
	logic [7:0]  q_c, t_c;

	assign busy = 1'b0;

	always_comb begin
		fold1 = {1'b0, hue[15:8]} + {1'b0, hue[7:0]};
		fold2 = {1'b0, fold1[7:0]} + {8'd0, fold1[8]};
		hm_c  = (fold2[7:0] == STEPS8) ? 8'd0 : fold2[7:0];
	end

	always_comb begin
		pos_c = {1'b0, hm_s1, 2'b00} + {2'b00, hm_s1, 1'b0};
		if (pos_c >= 11'd1275) begin
			sec_c  = SEC_MAG_RED;
			base_c = 11'd1275;
		end else if (pos_c >= 11'd1020) begin
			sec_c  = SEC_BLU_MAG;
			base_c = 11'd1020;
		end else if (pos_c >= 11'd765) begin
			sec_c  = SEC_CYN_BLU;
			base_c = 11'd765;
		end else if (pos_c >= 11'd510) begin
			sec_c  = SEC_GRN_CYN;
			base_c = 11'd510;
		end else if (pos_c >= 11'd255) begin
			sec_c  = SEC_YEL_GRN;
			base_c = 11'd255;
		end else begin
			sec_c  = SEC_RED_YEL;
			base_c = 11'd0;
		end
	end

	// x / 255 for x below 65280
	always_comb begin
		psum_c = {1'b0, pprod_s2} + {9'd0, pprod_s2[15:8]} + 17'd1;
		p_c    = psum_c[15:8];
		remb_c = {8'd0, STEPS8 - rem_s2};
	end

	// e * 511 with e the top byte of the product
	always_comb begin
		eq511_c = {prodq_s4[23:16], 9'd0} - {9'd0, prodq_s4[23:16]};
		et511_c = {prodt_s4[23:16], 9'd0} - {9'd0, prodt_s4[23:16]};
	end

	always_comb begin
		q_c = eq_s5 + {7'd0, rq_s5 >= FULL18} + {7'd0, rq_s5 >= FULL18X2};
		t_c = et_s5 + {7'd0, rt_s5 >= FULL18} + {7'd0, rt_s5 >= FULL18X2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		hm_s1  <= hm_c;
		sat_s1 <= saturation;
		bri_s1 <= brightness;

		sec_s2   <= sec_c;
		rem_s2   <= 8'(pos_c - base_c);
		pprod_s2 <= {8'd0, bri_s1} * {8'd0, STEPS8 - sat_s1};
		sat_s2   <= sat_s1;
		bri_s2   <= bri_s1;

		sec_s3   <= sec_s2;
		lossq_s3 <= {8'd0, sat_s2} * {8'd0, rem_s2};
		losst_s3 <= {8'd0, sat_s2} * remb_c;
		p_s3     <= p_c;
		bri_s3   <= bri_s2;

		sec_s4   <= sec_s3;
		prodq_s4 <= {16'd0, bri_s3} * {8'd0, FULL16 - lossq_s3};
		prodt_s4 <= {16'd0, bri_s3} * {8'd0, FULL16 - losst_s3};
		p_s4     <= p_s3;
		bri_s4   <= bri_s3;

		sec_s5 <= sec_s4;
		eq_s5  <= prodq_s4[23:16];
		et_s5  <= prodt_s4[23:16];
		rq_s5  <= {2'b00, prodq_s4[15:0]} + {1'b0, eq511_c};
		rt_s5  <= {2'b00, prodt_s4[15:0]} + {1'b0, et511_c};
		p_s5   <= p_s4;
		bri_s5 <= bri_s4;

		case (sec_s5)
			SEC_RED_YEL: begin
				red_s6 <= bri_s5; green_s6 <= t_c;    blue_s6 <= p_s5;
			end
			SEC_YEL_GRN: begin
				red_s6 <= q_c;    green_s6 <= bri_s5; blue_s6 <= p_s5;
			end
			SEC_GRN_CYN: begin
				red_s6 <= p_s5;   green_s6 <= bri_s5; blue_s6 <= t_c;
			end
			SEC_CYN_BLU: begin
				red_s6 <= p_s5;   green_s6 <= q_c;    blue_s6 <= bri_s5;
			end
			SEC_BLU_MAG: begin
				red_s6 <= t_c;    green_s6 <= p_s5;   blue_s6 <= bri_s5;
			end
			default: begin
				red_s6 <= bri_s5; green_s6 <= p_s5;   blue_s6 <= q_c;
			end
		endcase
	end

	assign done  = vld_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

endmodule
